FILE: src/isa_dma_channel_program_sequencer_defines.svh
// ----------------------------------------------------------------------------
// ISA DMA channel program sequencer: assertion macros
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ISA_DMA_CHANNEL_PROGRAM_SEQUENCER_DEFINES_SVH
`define ISA_DMA_CHANNEL_PROGRAM_SEQUENCER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// property must hold at every clock edge out of reset
`define ISA_DMA_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// condition must never be seen at a clock edge out of reset
`define ISA_DMA_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ISA_DMA_ASSERT(name, prop)
`define ISA_DMA_ASSERT_NEVER(name, cond)
`endif
`endif

FILE: src/isa_dma_pkg.sv
// ----------------------------------------------------------------------------
// ISA DMA channel program sequencer: package
// Shared types, port addresses and port lookup functions.
// ----------------------------------------------------------------------------
package isa_dma_pkg;

  // command queue between the front and back ends; depth a power of two
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueueAw    = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  localparam logic [7:0] PriMaskPort = 8'h0A;
  localparam logic [7:0] PriModePort = 8'h0B;
  localparam logic [7:0] PriFfPort   = 8'h0C;
  localparam logic [7:0] SecMaskPort = 8'hD4;
  localparam logic [7:0] SecModePort = 8'hD6;
  localparam logic [7:0] SecFfPort   = 8'hD8;
  localparam logic [7:0] MaskSetBit  = 8'h04;

  typedef enum logic [1:0] {
    StatusOk         = 2'd0,
    StatusBadChan    = 2'd1,
    StatusZeroLen    = 2'd2,
    StatusMisaligned = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    StepMask   = 4'd0,
    StepClrFf1 = 4'd1,
    StepMode   = 4'd2,
    StepAddrLo = 4'd3,
    StepAddrHi = 4'd4,
    StepPage   = 4'd5,
    StepClrFf2 = 4'd6,
    StepCntLo  = 4'd7,
    StepCntHi  = 4'd8,
    StepUnmask = 4'd9
  } step_e;

  // classified request, as held in the command queue
  typedef struct packed {
    status_e     status;
    logic [2:0]  chan;
    logic [15:0] word_addr;
    logic [15:0] count;
    logic [7:0]  page;
    logic [7:0]  mode;
  } cmd_t;

  function automatic logic [7:0] addr_port(input logic [2:0] chan);
    logic [7:0] p;
    unique case (chan)
      3'd0: p = 8'h00;
      3'd1: p = 8'h02;
      3'd2: p = 8'h04;
      3'd3: p = 8'h06;
      3'd4: p = 8'hC0;
      3'd5: p = 8'hC4;
      3'd6: p = 8'hC8;
      default: p = 8'hCC;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] cnt_reg_port(input logic [2:0] chan);
    logic [7:0] p;
    unique case (chan)
      3'd0: p = 8'h01;
      3'd1: p = 8'h03;
      3'd2: p = 8'h05;
      3'd3: p = 8'h07;
      3'd4: p = 8'hC2;
      3'd5: p = 8'hC6;
      3'd6: p = 8'hCA;
      default: p = 8'hCE;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] page_port(input logic [2:0] chan);
    logic [7:0] p;
    unique case (chan)
      3'd0: p = 8'h87;
      3'd1: p = 8'h83;
      3'd2: p = 8'h81;
      3'd3: p = 8'h82;
      3'd4: p = 8'h8F;
      3'd5: p = 8'h8B;
      3'd6: p = 8'h89;
      default: p = 8'h8A;
    endcase
    return p;
  endfunction

endpackage

FILE: src/isa_dma_front.sv
// ----------------------------------------------------------------------------
// ISA DMA front end
// Checks a request and turns it into a queued command: error status, address
// and count (word-scaled on the wide channels), page and merged mode byte.
// ----------------------------------------------------------------------------
module isa_dma_front (
  input  logic                start_i,
  input  logic                q_full_i,
  input  logic [2:0]          chan_num_i,
  input  logic [23:0]         phys_addr_i,
  input  logic [15:0]         byte_len_i,
  input  logic [7:0]          mode_byte_i,
  output logic                busy_o,
  output logic                push_o,
  output isa_dma_pkg::cmd_t   cmd_o
);

  logic        wide;
  logic [15:0] len_units;

  assign wide      = chan_num_i[2];
  assign len_units = wide ? {1'b0, byte_len_i[15:1]} : byte_len_i;

  assign busy_o = q_full_i;
  assign push_o = start_i && !q_full_i;

  always_comb begin
    cmd_o.chan      = chan_num_i;
    cmd_o.word_addr = wide ? phys_addr_i[16:1] : phys_addr_i[15:0];
    cmd_o.count     = len_units - 16'd1;
    cmd_o.page      = phys_addr_i[23:16];
    cmd_o.mode      = {mode_byte_i[7:2], chan_num_i[1:0]};
    // order decides: channel first, then length, then alignment
    priority if (chan_num_i == 3'd4) begin
      cmd_o.status = isa_dma_pkg::StatusBadChan;
    end else if (byte_len_i == 16'd0) begin
      cmd_o.status = isa_dma_pkg::StatusZeroLen;
    end else if (wide && (phys_addr_i[0] || byte_len_i[0])) begin
      cmd_o.status = isa_dma_pkg::StatusMisaligned;
    end else begin
      cmd_o.status = isa_dma_pkg::StatusOk;
    end
  end

endmodule

FILE: src/isa_dma_queue.sv
// ----------------------------------------------------------------------------
// ISA DMA command queue
// Short register queue that decouples the front and back ends.
// ----------------------------------------------------------------------------
`include "isa_dma_channel_program_sequencer_defines.svh"

module isa_dma_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  isa_dma_pkg::cmd_t  cmd_i,
  input  logic               pop_i,
  output logic               full_o,
  output logic               empty_o,
  output isa_dma_pkg::cmd_t  head_o
);

  localparam int unsigned Aw = isa_dma_pkg::QueueAw;

  isa_dma_pkg::cmd_t entries_q [isa_dma_pkg::QueueDepth];
  logic [Aw-1:0] wr_ptr_q, wr_ptr_d;
  logic [Aw-1:0] rd_ptr_q, rd_ptr_d;
  logic [Aw:0]   fill_q, fill_d;

  assign full_o  = (fill_q == (Aw+1)'(isa_dma_pkg::QueueDepth));
  assign empty_o = (fill_q == '0);
  assign head_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    fill_d   = fill_q + {{Aw{1'b0}}, push_i} - {{Aw{1'b0}}, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

  `ISA_DMA_ASSERT_NEVER(a_no_overflow, push_i && full_o)
  `ISA_DMA_ASSERT_NEVER(a_no_underflow, pop_i && empty_o)

endmodule

FILE: src/isa_dma_back.sv
// ----------------------------------------------------------------------------
// ISA DMA back end
// Walks the head command through the ten port writes, one per cycle, or
// reports its error in a single result.
// ----------------------------------------------------------------------------
`include "isa_dma_channel_program_sequencer_defines.svh"

module isa_dma_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  isa_dma_pkg::cmd_t  head_i,
  output logic               pop_o,
  output logic               strobe_o,
  output logic               write_valid_o,
  output logic [7:0]         port_addr_o,
  output logic [7:0]         port_data_o,
  output logic [1:0]         status_o,
  output logic               last_write_o
);

  isa_dma_pkg::step_e step_q, step_d;

  logic       strobe_q, strobe_d;
  logic       wv_q, wv_d;
  logic [7:0] port_q, port_d;
  logic [7:0] data_q, data_d;
  logic [1:0] status_q, status_d;
  logic       last_q, last_d;

  logic       wide;
  logic       is_err;
  logic [7:0] mask_port, mode_reg_port, ff_port;
  logic [7:0] local_chan;

  assign wide          = head_i.chan[2];
  assign is_err        = (head_i.status != isa_dma_pkg::StatusOk);
  assign mask_port     = wide ? isa_dma_pkg::SecMaskPort : isa_dma_pkg::PriMaskPort;
  assign mode_reg_port = wide ? isa_dma_pkg::SecModePort : isa_dma_pkg::PriModePort;
  assign ff_port       = wide ? isa_dma_pkg::SecFfPort : isa_dma_pkg::PriFfPort;
  assign local_chan    = {6'd0, head_i.chan[1:0]};

  always_comb begin
    strobe_d = !empty_i;
    wv_d     = 1'b0;
    port_d   = 8'd0;
    data_d   = 8'd0;
    status_d = head_i.status;
    last_d   = 1'b1;
    step_d   = step_q;
    pop_o    = 1'b0;

    if (!empty_i) begin
      if (is_err) begin
        pop_o = 1'b1;
      end else begin
        wv_d   = 1'b1;
        last_d = (step_q == isa_dma_pkg::StepUnmask);
        unique case (step_q)
          isa_dma_pkg::StepMask: begin
            port_d = mask_port;
            data_d = isa_dma_pkg::MaskSetBit | local_chan;
          end
          isa_dma_pkg::StepClrFf1, isa_dma_pkg::StepClrFf2: begin
            port_d = ff_port;
          end
          isa_dma_pkg::StepMode: begin
            port_d = mode_reg_port;
            data_d = head_i.mode;
          end
          isa_dma_pkg::StepAddrLo: begin
            port_d = isa_dma_pkg::addr_port(head_i.chan);
            data_d = head_i.word_addr[7:0];
          end
          isa_dma_pkg::StepAddrHi: begin
            port_d = isa_dma_pkg::addr_port(head_i.chan);
            data_d = head_i.word_addr[15:8];
          end
          isa_dma_pkg::StepPage: begin
            port_d = isa_dma_pkg::page_port(head_i.chan);
            data_d = head_i.page;
          end
          isa_dma_pkg::StepCntLo: begin
            port_d = isa_dma_pkg::cnt_reg_port(head_i.chan);
            data_d = head_i.count[7:0];
          end
          isa_dma_pkg::StepCntHi: begin
            port_d = isa_dma_pkg::cnt_reg_port(head_i.chan);
            data_d = head_i.count[15:8];
          end
          isa_dma_pkg::StepUnmask: begin
            port_d = mask_port;
            data_d = local_chan;
          end
          default: begin
            port_d = 8'd0;
          end
        endcase
        // advance, or drop the command after the unmask write
        if (step_q == isa_dma_pkg::StepUnmask) begin
          pop_o  = 1'b1;
          step_d = isa_dma_pkg::StepMask;
        end else begin
          step_d = isa_dma_pkg::step_e'(step_q + 4'd1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= isa_dma_pkg::StepMask;
      strobe_q <= 1'b0;
    end else begin
      step_q   <= step_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wv_q     <= wv_d;
    port_q   <= port_d;
    data_q   <= data_d;
    status_q <= status_d;
    last_q   <= last_d;
  end

  assign strobe_o      = strobe_q;
  assign write_valid_o = wv_q;
  assign port_addr_o   = port_q;
  assign port_data_o   = data_q;
  assign status_o      = status_q;
  assign last_write_o  = last_q;

  `ISA_DMA_ASSERT(a_err_is_last, (strobe_q && !wv_q) |-> (last_q && status_q != isa_dma_pkg::StatusOk))
  `ISA_DMA_ASSERT(a_write_ok, (strobe_q && wv_q) |-> (status_q == isa_dma_pkg::StatusOk))
  `ISA_DMA_ASSERT(a_step_idle_hold, empty_i |=> $stable(step_q))

endmodule

FILE: src/isa_dma_channel_program_sequencer.sv
// ----------------------------------------------------------------------------
// ISA DMA channel program sequencer: top level
// A request to program a DMA channel is taken on start_i while busy_o is
// low. A valid request yields ten port writes on consecutive cycles
// (mask, clear flip-flop, mode, address low/high, page, clear flip-flop,
// count low/high, unmask); a rejected one yields a single error result.
// Each result is shown for exactly one cycle with strobe_o high and cannot
// be held off. The back-end sequencer emits one result per cycle while the
// queue holds a command, finishing one request before it starts the next;
// a taken request is written into the queue and its results pass through
// the back end's output registers. A two-entry command queue lets the
// front end take further requests while writes go out; busy_o is high only
// while that queue is full.
// ----------------------------------------------------------------------------
module isa_dma_channel_program_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  chan_num_i,
  input  logic [23:0] phys_addr_i,
  input  logic [15:0] byte_len_i,
  input  logic [7:0]  mode_byte_i,
  output logic        strobe_o,
  output logic        write_valid_o,
  output logic [7:0]  port_addr_o,
  output logic [7:0]  port_data_o,
  output logic [1:0]  status_o,
  output logic        last_write_o
);

  logic              push;
  logic              pop;
  logic              q_full;
  logic              q_empty;
  isa_dma_pkg::cmd_t cmd;
  isa_dma_pkg::cmd_t head;

  isa_dma_front u_front (
    .start_i     (start_i),
    .q_full_i    (q_full),
    .chan_num_i  (chan_num_i),
    .phys_addr_i (phys_addr_i),
    .byte_len_i  (byte_len_i),
    .mode_byte_i (mode_byte_i),
    .busy_o      (busy_o),
    .push_o      (push),
    .cmd_o       (cmd)
  );

  isa_dma_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head)
  );

  isa_dma_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (q_empty),
    .head_i        (head),
    .pop_o         (pop),
    .strobe_o      (strobe_o),
    .write_valid_o (write_valid_o),
    .port_addr_o   (port_addr_o),
    .port_data_o   (port_data_o),
    .status_o      (status_o),
    .last_write_o  (last_write_o)
  );

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// ISA DMA channel program sequencer: testbench
// Feeds channel programming requests through the start/busy handshake,
// expands each accepted request into its expected port writes or error
// report, and checks every strobed result against the oldest one due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  typedef struct {
    logic [2:0]  chan;
    logic [23:0] addr;
    logic [15:0] len;
    logic [7:0]  mode;
    int unsigned idle_pct;
    bit          drain;
  } dma_req_t;

  typedef struct {
    logic                 wr;
    logic [7:0]           port;
    logic [7:0]           data;
    isa_dma_pkg::status_e status;
    logic                 last;
  } dma_write_t;

  localparam logic [7:0] AddrPorts  [8] = '{8'h00, 8'h02, 8'h04, 8'h06,
                                            8'hC0, 8'hC4, 8'hC8, 8'hCC};
  localparam logic [7:0] CountPorts [8] = '{8'h01, 8'h03, 8'h05, 8'h07,
                                            8'hC2, 8'hC6, 8'hCA, 8'hCE};
  localparam logic [7:0] PagePorts  [8] = '{8'h87, 8'h83, 8'h81, 8'h82,
                                            8'h8F, 8'h8B, 8'h89, 8'h8A};
  localparam int unsigned RandomItems = 150;
  localparam int unsigned TailCycles  = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [2:0]  chan_num_i = '0;
  logic [23:0] phys_addr_i = '0;
  logic [15:0] byte_len_i = '0;
  logic [7:0]  mode_byte_i = '0;
  logic        strobe_o;
  logic        write_valid_o;
  logic [7:0]  port_addr_o;
  logic [7:0]  port_data_o;
  logic [1:0]  status_o;
  logic        last_write_o;

  dma_req_t    req_pending[$];
  dma_write_t  writes_due[$];
  dma_req_t    req_on_bus;
  int unsigned n_errors = 0;

  isa_dma_channel_program_sequencer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .chan_num_i    (chan_num_i),
    .phys_addr_i   (phys_addr_i),
    .byte_len_i    (byte_len_i),
    .mode_byte_i   (mode_byte_i),
    .strobe_o      (strobe_o),
    .write_valid_o (write_valid_o),
    .port_addr_o   (port_addr_o),
    .port_data_o   (port_data_o),
    .status_o      (status_o),
    .last_write_o  (last_write_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic dma_req_t mk_req(logic [2:0] chan, logic [23:0] addr,
                                      logic [15:0] len, logic [7:0] mode,
                                      int unsigned idle_pct, bit drain);
    dma_req_t r;
    r.chan = chan;
    r.addr = addr;
    r.len = len;
    r.mode = mode;
    r.idle_pct = idle_pct;
    r.drain = drain;
    return r;
  endfunction

  function automatic void push_write(logic wr, logic [7:0] port, logic [7:0] data,
                                     isa_dma_pkg::status_e status, logic last);
    dma_write_t w;
    w.wr = wr;
    w.port = port;
    w.data = data;
    w.status = status;
    w.last = last;
    writes_due.push_back(w);
  endfunction

  // Expand one request into the port writes it programs, or its error report
  function automatic void expand_request(dma_req_t r);
    logic        wide;
    logic [1:0]  lch;
    logic [15:0] waddr;
    logic [15:0] cnt;
    logic [7:0]  mask_p;
    logic [7:0]  mode_p;
    logic [7:0]  ff_p;
    wide = r.chan[2];
    lch = r.chan[1:0];
    if (r.chan == 3'd4) begin
      push_write(1'b0, 8'h00, 8'h00, isa_dma_pkg::StatusBadChan, 1'b1);
      return;
    end
    if (r.len == 16'd0) begin
      push_write(1'b0, 8'h00, 8'h00, isa_dma_pkg::StatusZeroLen, 1'b1);
      return;
    end
    if (wide && (r.addr[0] || r.len[0])) begin
      push_write(1'b0, 8'h00, 8'h00, isa_dma_pkg::StatusMisaligned, 1'b1);
      return;
    end
    if (wide) begin
      waddr = r.addr[16:1];
      cnt = {1'b0, r.len[15:1]} - 16'd1;
      mask_p = isa_dma_pkg::SecMaskPort;
      mode_p = isa_dma_pkg::SecModePort;
      ff_p = isa_dma_pkg::SecFfPort;
    end else begin
      waddr = r.addr[15:0];
      cnt = r.len - 16'd1;
      mask_p = isa_dma_pkg::PriMaskPort;
      mode_p = isa_dma_pkg::PriModePort;
      ff_p = isa_dma_pkg::PriFfPort;
    end
    push_write(1'b1, mask_p, isa_dma_pkg::MaskSetBit | {6'd0, lch},
               isa_dma_pkg::StatusOk, 1'b0);
    push_write(1'b1, ff_p, 8'h00, isa_dma_pkg::StatusOk, 1'b0);
    push_write(1'b1, mode_p, {r.mode[7:2], lch}, isa_dma_pkg::StatusOk, 1'b0);
    push_write(1'b1, AddrPorts[r.chan], waddr[7:0], isa_dma_pkg::StatusOk, 1'b0);
    push_write(1'b1, AddrPorts[r.chan], waddr[15:8], isa_dma_pkg::StatusOk, 1'b0);
    push_write(1'b1, PagePorts[r.chan], r.addr[23:16], isa_dma_pkg::StatusOk, 1'b0);
    push_write(1'b1, ff_p, 8'h00, isa_dma_pkg::StatusOk, 1'b0);
    push_write(1'b1, CountPorts[r.chan], cnt[7:0], isa_dma_pkg::StatusOk, 1'b0);
    push_write(1'b1, CountPorts[r.chan], cnt[15:8], isa_dma_pkg::StatusOk, 1'b0);
    push_write(1'b1, mask_p, {6'd0, lch}, isa_dma_pkg::StatusOk, 1'b1);
  endfunction

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      n_errors++;
    end
  endfunction

  // Driver: present the next pending request, hold it while busy_o is high
  always @(posedge clk_i) begin
    dma_req_t nxt;
    bit       taken;
    bit       go;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      taken = start_i && !busy_o;
      if (taken) expand_request(req_on_bus);
      if (!(start_i && !taken)) begin
        go = 1'b0;
        if (req_pending.size() != 0) begin
          go = $urandom_range(99) >= req_pending[0].idle_pct;
          // hold off until every write due has come out
          if (req_pending[0].drain && (writes_due.size() != 0 || strobe_o)) go = 1'b0;
        end
        if (go) begin
          nxt = req_pending.pop_front();
          req_on_bus = nxt;
          start_i <= 1'b1;
          chan_num_i <= nxt.chan;
          phys_addr_i <= nxt.addr;
          byte_len_i <= nxt.len;
          mode_byte_i <= nxt.mode;
        end else begin
          start_i <= 1'b0;
          chan_num_i <= 3'($urandom);
          phys_addr_i <= 24'($urandom);
          byte_len_i <= 16'($urandom);
          mode_byte_i <= 8'($urandom);
        end
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest write due
  always @(posedge clk_i) begin
    dma_write_t w;
    if (rst_ni && strobe_o) begin
      if (writes_due.size() == 0) begin
        $display("%0t: unexpected result, got valid %0b port %0h data %0h status %0d last %0b",
                 $time, write_valid_o, port_addr_o, port_data_o, status_o, last_write_o);
        n_errors++;
      end else begin
        w = writes_due.pop_front();
        check_field("write_valid", {7'd0, w.wr}, {7'd0, write_valid_o});
        check_field("port_addr", w.port, port_addr_o);
        check_field("port_data", w.data, port_data_o);
        check_field("status", {6'd0, w.status}, {6'd0, status_o});
        check_field("last_write", {7'd0, w.last}, {7'd0, last_write_o});
      end
    end
  end

  initial begin
    dma_req_t    r;
    int unsigned idle_pct;
    int unsigned kind;
    // directed: every channel, both field extremes, each rejection
    req_pending.push_back(mk_req(3'd0, 24'h000000, 16'd1, 8'h00, 0, 1'b0));
    req_pending.push_back(mk_req(3'd1, 24'hFFFFFF, 16'hFFFF, 8'hFF, 0, 1'b0));
    req_pending.push_back(mk_req(3'd2, 24'h123456, 16'h0100, 8'h5A, 0, 1'b0));
    req_pending.push_back(mk_req(3'd3, 24'hABCDEF, 16'h8001, 8'hA7, 0, 1'b0));
    req_pending.push_back(mk_req(3'd5, 24'h000000, 16'd2, 8'hFF, 0, 1'b0));
    req_pending.push_back(mk_req(3'd6, 24'hFFFFFE, 16'hFFFE, 8'h00, 0, 1'b0));
    req_pending.push_back(mk_req(3'd7, 24'h2468AC, 16'h1000, 8'h96, 0, 1'b0));
    req_pending.push_back(mk_req(3'd4, 24'h001000, 16'h0010, 8'h44, 0, 1'b0));
    req_pending.push_back(mk_req(3'd4, 24'h000001, 16'd0, 8'hFF, 0, 1'b0));
    req_pending.push_back(mk_req(3'd0, 24'h00FFFF, 16'd0, 8'h11, 0, 1'b0));
    req_pending.push_back(mk_req(3'd5, 24'h000002, 16'd0, 8'h22, 0, 1'b0));
    req_pending.push_back(mk_req(3'd6, 24'h000001, 16'd4, 8'h33, 0, 1'b0));
    req_pending.push_back(mk_req(3'd7, 24'h000002, 16'd3, 8'h44, 0, 1'b0));
    req_pending.push_back(mk_req(3'd5, 24'hFFFFFF, 16'hFFFF, 8'h55, 0, 1'b0));
    req_pending.push_back(mk_req(3'd3, 24'hFFFFFF, 16'd1, 8'hFC, 0, 1'b1));
    req_pending.push_back(mk_req(3'd7, 24'h7FFFFE, 16'd2, 8'h03, 0, 1'b0));
    req_pending.push_back(mk_req(3'd4, 24'hFFFFFF, 16'hFFFF, 8'h00, 0, 1'b0));
    req_pending.push_back(mk_req(3'd2, 24'h010001, 16'd1, 8'h01, 0, 1'b0));
    req_pending.push_back(mk_req(3'd6, 24'h010000, 16'h0002, 8'hFE, 0, 1'b0));
    req_pending.push_back(mk_req(3'd1, 24'h800000, 16'd0, 8'h80, 0, 1'b0));
    // random phases: no idling, sender idle 49 %, no idling, sender idle 23 %
    for (int unsigned i = 0; i < RandomItems; i++) begin
      case ((i * 4) / RandomItems)
        0: idle_pct = 0;
        1: idle_pct = 49;
        2: idle_pct = 0;
        default: idle_pct = 23;
      endcase
      kind = $urandom_range(9);
      r.chan = 3'($urandom);
      r.addr = 24'($urandom);
      r.len = 16'($urandom);
      r.mode = 8'($urandom);
      if (kind < 7) begin
        // well-formed request with random content
        if (r.chan == 3'd4) r.chan = 3'($urandom_range(7, 5));
        if (r.chan[2]) begin
          r.addr[0] = 1'b0;
          r.len[0] = 1'b0;
        end
        if ($urandom_range(7) == 0) r.len = r.chan[2] ? 16'd2 : 16'd1;
        if (r.len == 16'd0) r.len = 16'hFFFE;
      end else if (kind == 7) begin
        r.len = 16'd0;
      end
      r.idle_pct = idle_pct;
      r.drain = ((i * 4) % RandomItems < 4) || ($urandom_range(19) == 0);
      req_pending.push_back(r);
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_pending.size() != 0 || start_i || writes_due.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("PASS isa_dma_channel_program_sequencer");
    end else begin
      $display("FAIL isa_dma_channel_program_sequencer");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout waiting for results");
    $display("FAIL isa_dma_channel_program_sequencer");
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/isa_dma_pkg.sv
src/isa_dma_front.sv
src/isa_dma_queue.sv
src/isa_dma_back.sv
src/isa_dma_channel_program_sequencer.sv
sim/tb.sv
